[rtl/fbc_pkg.sv]
// fbc_pkg: shared widths, reset values, command and register codes, and
// the configuration and crop geometry structs of the bounding box crop block.
// No dependencies.
package fbc_pkg;

  localparam int CMD_W  = 2;
  localparam int ROW_W  = 9;
  localparam int COL_W  = 9;
  localparam int PIX_W  = 16;
  localparam int DIM_W  = 10;
  localparam int MRG_W  = 8;
  localparam int CROP_W = 9;
  localparam int SIZE_W = 10;
  // internal width of crop arithmetic, holds values up to 16383
  localparam int GEO_W  = 14;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam int DEF_MAX_COLS   = 512;
  localparam int DEF_MAX_ROWS   = 512;
  localparam int DEF_PIXEL_BITS = 16;

  localparam logic [DIM_W-1:0] COLS_RST   = 10'd512;
  localparam logic [DIM_W-1:0] ROWS_RST   = 10'd512;
  localparam logic [MRG_W-1:0] MARGIN_RST = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 2'd0,
    CMD_READ      = 2'd1,
    CMD_NEW_FRAME = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_COLS   = 2'd0,
    REG_ROWS   = 2'd1,
    REG_MARGIN = 2'd2
  } reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic [MRG_W-1:0] margin;
  } cfg_t;

  typedef struct packed {
    logic [CROP_W-1:0] left;
    logic [CROP_W-1:0] top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              empty;
  } geo_t;

endpackage

[rtl/fbc_if.sv]
// fbc_in_if, fbc_out_if: valid/ready channels carrying command beats in and
// result beats out. Depends on fbc_pkg.
interface fbc_in_if;
  logic                     valid;
  logic                     ready;
  logic [fbc_pkg::CMD_W-1:0] cmd;
  logic [fbc_pkg::ROW_W-1:0] row;
  logic [fbc_pkg::COL_W-1:0] col;
  logic [fbc_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, cmd, row, col, pixel_in, input ready);
  modport sink (input valid, cmd, row, col, pixel_in, output ready);
endinterface

interface fbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [fbc_pkg::PIX_W-1:0]  pixel_out;
  logic [fbc_pkg::CROP_W-1:0] crop_left;
  logic [fbc_pkg::CROP_W-1:0] crop_top;
  logic [fbc_pkg::SIZE_W-1:0] crop_width;
  logic [fbc_pkg::SIZE_W-1:0] crop_height;
  logic                      empty_res;
  logic                      out_of_range;

  modport source (output valid, pixel_out, crop_left, crop_top, crop_width, crop_height,
                  empty_res, out_of_range, input ready);
  modport sink (input valid, pixel_out, crop_left, crop_top, crop_width, crop_height,
                empty_res, out_of_range, output ready);
endinterface

[rtl/foreground_bbox_crop.sv]
// foreground_bbox_crop: frame store with foreground bounding box and margin crop read-out.
// Depends on fbc_pkg, fbc_if, fbc_ram, fbc_cfg and fbc_box.
//
// Takes one command beat per clock while the output is not stalled and returns one
// result beat per command: an input register, then box update, crop geometry and
// one access of the single-port frame memory, whose registered read data sits
// beside the result register. Writes store a pixel and widen the box on nonzero
// values, reads fetch the pixel at an offset inside the crop, new-frame clears the
// box and keeps the pixels. Each result carries the crop geometry after the command.
// Pixels never written read back as whatever the memory holds; the memory has no
// clearing pass. A stalled output holds the whole pipeline.
module foreground_bbox_crop #(
  parameter int MAX_COLS   = fbc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = fbc_pkg::DEF_MAX_ROWS,
  parameter int PIXEL_BITS = fbc_pkg::DEF_PIXEL_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbc_pkg::APB_AW-1:0] paddr,
  input  logic [fbc_pkg::APB_DW-1:0] pwdata,
  output logic [fbc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  fbc_in_if.sink                     in_beat,
  fbc_out_if.source                  out_beat
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int GEO_W  = fbc_pkg::GEO_W;

  fbc_pkg::cfg_t cfg;
  fbc_pkg::geo_t geo, geo_q;

  logic                          advance;
  logic                          s1_valid_q;
  fbc_pkg::cmd_e                 s1_cmd_q;
  logic [fbc_pkg::ROW_W-1:0]     s1_row_q;
  logic [fbc_pkg::COL_W-1:0]     s1_col_q;
  logic [PIXEL_BITS-1:0]         s1_pix_q;

  logic [GEO_W-1:0]  cols_eff, rows_eff, row_sel, col_sel;
  logic              upd, is_wr, is_rd, wr_ok, rd_ok, oor;
  logic [ADDR_W-1:0] addr;
  logic [PIXEL_BITS-1:0] ram_q;

  logic out_valid_q, oor_q, rd_ok_q;

  fbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  assign advance       = !out_valid_q || out_beat.ready;
  assign in_beat.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_beat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_beat.valid) begin
      s1_cmd_q <= fbc_pkg::cmd_e'(in_beat.cmd);
      s1_row_q <= in_beat.row;
      s1_col_q <= in_beat.col;
      s1_pix_q <= in_beat.pixel_in[PIXEL_BITS-1:0];
    end
  end

  // effective image size
  assign cols_eff = (GEO_W'(cfg.cols) > GEO_W'(MAX_COLS)) ? GEO_W'(MAX_COLS) : GEO_W'(cfg.cols);
  assign rows_eff = (GEO_W'(cfg.rows) > GEO_W'(MAX_ROWS)) ? GEO_W'(MAX_ROWS) : GEO_W'(cfg.rows);

  assign upd   = s1_valid_q && advance;
  assign is_wr = (s1_cmd_q == fbc_pkg::CMD_WRITE);
  assign is_rd = (s1_cmd_q == fbc_pkg::CMD_READ);
  assign wr_ok = (GEO_W'(s1_row_q) < rows_eff) && (GEO_W'(s1_col_q) < cols_eff);

  fbc_box #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_box (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .cmd_i    (s1_cmd_q),
    .row_i    (s1_row_q),
    .col_i    (s1_col_q),
    .pix_nz_i (|s1_pix_q),
    .wr_ok_i  (wr_ok),
    .cols_i   (cols_eff),
    .rows_i   (rows_eff),
    .margin_i (cfg.margin),
    .geo_o    (geo)
  );

  assign rd_ok = is_rd && !geo.empty &&
                 (fbc_pkg::SIZE_W'(s1_row_q) < geo.height) &&
                 (fbc_pkg::SIZE_W'(s1_col_q) < geo.width);
  assign oor   = (is_wr && !wr_ok) || (is_rd && !rd_ok);

  // frame memory address, image position for writes, crop offset for reads
  assign row_sel = is_rd ? GEO_W'(geo.top) + GEO_W'(s1_row_q) : GEO_W'(s1_row_q);
  assign col_sel = is_rd ? GEO_W'(geo.left) + GEO_W'(s1_col_q) : GEO_W'(s1_col_q);
  assign addr    = ADDR_W'(row_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(col_sel);

  fbc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (upd && is_wr && wr_ok),
    .re_i    (upd && rd_ok),
    .addr_i  (addr),
    .wdata_i (s1_pix_q),
    .rdata_o (ram_q)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      geo_q   <= geo;
      oor_q   <= oor;
      rd_ok_q <= rd_ok;
    end
  end

  assign out_beat.valid        = out_valid_q;
  assign out_beat.pixel_out    = rd_ok_q ? fbc_pkg::PIX_W'(ram_q) : '0;
  assign out_beat.crop_left    = geo_q.left;
  assign out_beat.crop_top     = geo_q.top;
  assign out_beat.crop_width   = geo_q.width;
  assign out_beat.crop_height  = geo_q.height;
  assign out_beat.empty_res    = geo_q.empty;
  assign out_beat.out_of_range = oor_q;

endmodule

[rtl/fbc_ram.sv]
// fbc_ram: generic single-port RAM with registered read data.
// Depends on fbc_pkg for default sizes.
module fbc_ram #(
  parameter int WIDTH = fbc_pkg::DEF_PIXEL_BITS,
  parameter int DEPTH = fbc_pkg::DEF_MAX_ROWS * fbc_pkg::DEF_MAX_COLS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fbc_cfg.sv]
// fbc_cfg: APB-style register file for image size and crop margin.
// Depends on fbc_pkg.
module fbc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbc_pkg::APB_AW-1:0] paddr,
  input  logic [fbc_pkg::APB_DW-1:0] pwdata,
  output logic [fbc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output fbc_pkg::cfg_t              cfg_o
);

  fbc_pkg::cfg_t cfg_q;
  fbc_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = fbc_pkg::reg_e'(paddr[fbc_pkg::APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols   <= fbc_pkg::COLS_RST;
      cfg_q.rows   <= fbc_pkg::ROWS_RST;
      cfg_q.margin <= fbc_pkg::MARGIN_RST;
    end else if (wr_en) begin
      case (sel)
        fbc_pkg::REG_COLS:   cfg_q.cols   <= pwdata[fbc_pkg::DIM_W-1:0];
        fbc_pkg::REG_ROWS:   cfg_q.rows   <= pwdata[fbc_pkg::DIM_W-1:0];
        fbc_pkg::REG_MARGIN: cfg_q.margin <= pwdata[fbc_pkg::MRG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      fbc_pkg::REG_COLS:   prdata = fbc_pkg::APB_DW'(cfg_q.cols);
      fbc_pkg::REG_ROWS:   prdata = fbc_pkg::APB_DW'(cfg_q.rows);
      fbc_pkg::REG_MARGIN: prdata = fbc_pkg::APB_DW'(cfg_q.margin);
      default:             prdata = '0;
    endcase
  end

endmodule

[rtl/fbc_box.sv]
// fbc_box: bounding box of foreground pixels and the clamped crop geometry
// that follows from it after the current command. Depends on fbc_pkg.
module fbc_box #(
  parameter int MAX_COLS = fbc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = fbc_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  fbc_pkg::cmd_e               cmd_i,
  input  logic [fbc_pkg::ROW_W-1:0]   row_i,
  input  logic [fbc_pkg::COL_W-1:0]   col_i,
  input  logic                        pix_nz_i,
  input  logic                        wr_ok_i,
  input  logic [fbc_pkg::GEO_W-1:0]   cols_i,
  input  logic [fbc_pkg::GEO_W-1:0]   rows_i,
  input  logic [fbc_pkg::MRG_W-1:0]   margin_i,
  output fbc_pkg::geo_t               geo_o
);

  localparam logic [fbc_pkg::COL_W-1:0] LEFT_RST = fbc_pkg::COL_W'(MAX_COLS - 1);
  localparam logic [fbc_pkg::ROW_W-1:0] TOP_RST  = fbc_pkg::ROW_W'(MAX_ROWS - 1);

  typedef struct packed {
    logic [fbc_pkg::GEO_W-1:0] start;
    logic [fbc_pkg::GEO_W-1:0] size;
  } span_t;

  function automatic span_t crop_span(input logic [fbc_pkg::COL_W-1:0] lo,
                                      input logic [fbc_pkg::COL_W-1:0] hi,
                                      input logic [fbc_pkg::GEO_W-1:0] dim,
                                      input logic [fbc_pkg::MRG_W-1:0] m);
    logic [fbc_pkg::GEO_W-1:0] s;
    logic [fbc_pkg::GEO_W-1:0] e;
    span_t                     r;
    s = (fbc_pkg::GEO_W'(lo) > fbc_pkg::GEO_W'(m)) ?
        fbc_pkg::GEO_W'(lo) - fbc_pkg::GEO_W'(m) : '0;
    e = fbc_pkg::GEO_W'(hi) + fbc_pkg::GEO_W'(m);
    if (e > dim) begin
      e = dim;
    end
    r.start = s;
    r.size  = (e > s) ? e - s : '0;
    return r;
  endfunction

  logic [fbc_pkg::COL_W-1:0] left_q, left_d, right_q, right_d;
  logic [fbc_pkg::ROW_W-1:0] top_q, top_d, bot_q, bot_d;
  logic                      any_q, any_d;
  span_t                     sx, sy;

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    top_d   = top_q;
    bot_d   = bot_q;
    any_d   = any_q;
    case (cmd_i)
      fbc_pkg::CMD_WRITE: begin
        if (wr_ok_i && pix_nz_i) begin
          if (!any_q || col_i < left_q)  left_d  = col_i;
          if (!any_q || col_i > right_q) right_d = col_i;
          if (!any_q || row_i < top_q)   top_d   = row_i;
          if (!any_q || row_i > bot_q)   bot_d   = row_i;
          any_d = 1'b1;
        end
      end
      fbc_pkg::CMD_NEW_FRAME: begin
        left_d  = LEFT_RST;
        right_d = '0;
        top_d   = TOP_RST;
        bot_d   = '0;
        any_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LEFT_RST;
      right_q <= '0;
      top_q   <= TOP_RST;
      bot_q   <= '0;
      any_q   <= 1'b0;
    end else if (upd_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      any_q   <= any_d;
    end
  end

  always_comb begin
    sx = crop_span(left_d, right_d, cols_i, margin_i);
    sy = crop_span(top_d, bot_d, rows_i, margin_i);
    geo_o.empty = !any_d;
    if (any_d) begin
      geo_o.left   = fbc_pkg::CROP_W'(sx.start);
      geo_o.top    = fbc_pkg::CROP_W'(sy.start);
      geo_o.width  = fbc_pkg::SIZE_W'(sx.size);
      geo_o.height = fbc_pkg::SIZE_W'(sy.size);
    end else begin
      geo_o.left   = '0;
      geo_o.top    = '0;
      geo_o.width  = '0;
      geo_o.height = '0;
    end
  end

endmodule

[test/tb_foreground_bbox_crop.sv]
// tb_foreground_bbox_crop: self-checking bench for the bounding box crop block.
// Drives command beats with random bursts and stalls, predicts every result
// beat from a local model of frame store, box and crop; needs fbc_pkg, fbc_if and foreground_bbox_crop.
module tb_foreground_bbox_crop;
  import fbc_pkg::*;

  localparam int MAX_C = DEF_MAX_COLS;
  localparam int MAX_R = DEF_MAX_ROWS;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } px_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [CROP_W-1:0] left;
    logic [CROP_W-1:0] top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              empty;
    logic              oor;
  } crop_beat_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fbc_in_if  in_if ();
  fbc_out_if out_if ();

  foreground_bbox_crop u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_beat  (in_if),
    .out_beat (out_if)
  );

  // model copy 0 plans the stimulus, copy 1 predicts accepted beats
  bit [PIX_W-1:0] pix_store   [2][MAX_R*MAX_C];
  bit             pix_written [2][MAX_R*MAX_C];
  logic [8:0]     box_l [2];
  logic [8:0]     box_r [2];
  logic [8:0]     box_t [2];
  logic [8:0]     box_b [2];
  bit             box_fg [2];
  cfg_t           cfg;

  px_cmd_t    cmd_backlog [$];
  crop_beat_t result_due [$];
  int         recent_pix [$];
  int         planned;
  int         fail_cnt;

  px_cmd_t    drv_item;
  int         burst_left;
  int         gap_left;
  rx_mode_e   rx_mode;
  int         rx_left;
  bit         long_hold_done;
  crop_beat_t mon_exp;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int eff_cols();
    return (cfg.cols > MAX_C) ? MAX_C : int'(cfg.cols);
  endfunction

  function automatic int eff_rows();
    return (cfg.rows > MAX_R) ? MAX_R : int'(cfg.rows);
  endfunction

  function automatic void clear_box(int s);
    box_l[s] = 9'(MAX_C - 1);
    box_r[s] = '0;
    box_t[s] = 9'(MAX_R - 1);
    box_b[s] = '0;
    box_fg[s] = 1'b0;
  endfunction

  function automatic void crop_span(int lo, int hi, int dim, output int start,
                                    output int size);
    int mrg;
    int stop;
    mrg = int'(cfg.margin);
    start = (lo > mrg) ? lo - mrg : 0;
    stop = hi + mrg;
    if (stop > dim) stop = dim;
    size = (stop > start) ? stop - start : 0;
  endfunction

  function automatic void crop_geo(int s, output int l, output int t, output int w,
                                   output int h);
    l = 0;
    t = 0;
    w = 0;
    h = 0;
    if (box_fg[s]) begin
      crop_span(int'(box_l[s]), int'(box_r[s]), eff_cols(), l, w);
      crop_span(int'(box_t[s]), int'(box_b[s]), eff_rows(), t, h);
    end
  endfunction

  function automatic crop_beat_t crop_step(int s, px_cmd_t it);
    int         l, t, w, h, idx;
    int         row, col;
    crop_beat_t res;
    res = '0;
    row = int'(it.row);
    col = int'(it.col);
    case (it.cmd)
      CMD_WRITE: begin
        if (row < eff_rows() && col < eff_cols()) begin
          idx = row * MAX_C + col;
          pix_store[s][idx] = it.pix;
          pix_written[s][idx] = 1'b1;
          if (it.pix != '0) begin
            if (!box_fg[s] || it.col < box_l[s]) box_l[s] = it.col;
            if (!box_fg[s] || it.col > box_r[s]) box_r[s] = it.col;
            if (!box_fg[s] || it.row < box_t[s]) box_t[s] = it.row;
            if (!box_fg[s] || it.row > box_b[s]) box_b[s] = it.row;
            box_fg[s] = 1'b1;
          end
        end else begin
          res.oor = 1'b1;
        end
      end
      CMD_NEW_FRAME: clear_box(s);
      default: ;
    endcase
    crop_geo(s, l, t, w, h);
    if (it.cmd == CMD_READ) begin
      if (box_fg[s] && row < h && col < w) res.pixel = pix_store[s][(t + row) * MAX_C + l + col];
      else res.oor = 1'b1;
    end
    res.left = l[CROP_W-1:0];
    res.top = t[CROP_W-1:0];
    res.width = w[SIZE_W-1:0];
    res.height = h[SIZE_W-1:0];
    res.empty = !box_fg[s];
    return res;
  endfunction

  function automatic px_cmd_t mk(logic [CMD_W-1:0] cmd, int row, int col, int pix);
    px_cmd_t m;
    m.cmd = cmd;
    m.row = row[ROW_W-1:0];
    m.col = col[COL_W-1:0];
    m.pix = pix[PIX_W-1:0];
    return m;
  endfunction

  function automatic int rand_pix();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16'hFFFF;
      2: return 1 << $urandom_range(0, 15);
      default: return $urandom_range(1, 16'hFFFF);
    endcase
  endfunction

  // queue a beat; a read that would hit a never-written pixel gets that pixel written first
  function automatic void plan_item(px_cmd_t it);
    int l, t, w, h, r, c, v;
    if (it.cmd == CMD_READ) begin
      crop_geo(0, l, t, w, h);
      if (box_fg[0] && it.row < h && it.col < w) begin
        r = t + int'(it.row);
        c = l + int'(it.col);
        if (!pix_written[0][r * MAX_C + c]) begin
          v = (c >= box_l[0] && c <= box_r[0] && r >= box_t[0] && r <= box_b[0]) ? rand_pix() : 0;
          plan_item(mk(CMD_WRITE, r, c, v));
        end
      end
    end
    cmd_backlog.push_back(it);
    void'(crop_step(0, it));
    planned++;
    if (it.cmd == CMD_WRITE && it.row < eff_rows() && it.col < eff_cols()) begin
      recent_pix.push_back(int'(it.row) * MAX_C + int'(it.col));
      if (recent_pix.size() > 32) void'(recent_pix.pop_front());
    end
  endfunction

  function automatic void plan_read();
    int l, t, w, h, p, r, c;
    crop_geo(0, l, t, w, h);
    r = $urandom_range(0, 511);
    c = $urandom_range(0, 511);
    if (w > 0 && h > 0 && $urandom_range(0, 7) != 0) begin
      r = $urandom_range(0, h - 1);
      c = $urandom_range(0, w - 1);
      if (recent_pix.size() > 0 && $urandom_range(0, 1) == 1) begin
        p = recent_pix[$urandom_range(0, recent_pix.size() - 1)];
        if (p / MAX_C >= t && p / MAX_C < t + h && p % MAX_C >= l && p % MAX_C < l + w) begin
          r = p / MAX_C - t;
          c = p % MAX_C - l;
        end
      end
    end
    plan_item(mk(CMD_READ, r, c, $urandom_range(0, 16'hFFFF)));
  endfunction

  function automatic int near(int center, int spread, int dim);
    int v, hi;
    hi = (dim > 0) ? dim - 1 : 511;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic void plan_noise();
    int r, c;
    r = $urandom_range(0, 511);
    c = $urandom_range(0, 511);
    case ($urandom_range(0, 2))
      0: plan_item(mk(CMD_UNUSED, r, c, $urandom_range(0, 16'hFFFF)));
      1: plan_item(mk(CMD_READ, r, c, $urandom_range(0, 16'hFFFF)));
      default: begin
        // write past the image edge where the image allows it
        if (eff_rows() < MAX_R && $urandom_range(0, 1) == 1) r = $urandom_range(eff_rows(), 511);
        else if (eff_cols() < MAX_C) c = $urandom_range(eff_cols(), 511);
        plan_item(mk(CMD_WRITE, r, c, rand_pix()));
      end
    endcase
  endfunction

  function automatic void plan_traffic(int n);
    int stop, kind, rc, cc, spread;
    stop = planned + n;
    repeat (3) plan_read();
    plan_item(mk(CMD_UNUSED, 0, 0, 0));
    while (planned < stop) begin
      kind = $urandom_range(0, 9);
      rc = near(0, 0, eff_rows()) + $urandom_range(0, (eff_rows() > 0) ? eff_rows() - 1 : 511);
      cc = $urandom_range(0, (eff_cols() > 0) ? eff_cols() - 1 : 511);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      if (kind == 0) begin
        plan_noise();
      end else if (kind <= 3) begin
        plan_item(mk(CMD_NEW_FRAME, $urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 16'hFFFF)));
        repeat ($urandom_range(2, 10)) begin
          plan_item(mk(CMD_WRITE, near(rc, spread, eff_rows()), near(cc, spread, eff_cols()),
                       rand_pix()));
        end
        repeat ($urandom_range(2, 8)) plan_read();
      end else if (kind <= 5) begin
        repeat ($urandom_range(1, 4)) begin
          plan_item(mk(CMD_WRITE, near(rc, spread, eff_rows()), near(cc, spread, eff_cols()),
                       rand_pix()));
        end
      end else begin
        repeat ($urandom_range(1, 4)) plan_read();
      end
    end
  endfunction

  task automatic reg_write(reg_e idx, logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COLS:   cfg.cols = val[DIM_W-1:0];
      REG_ROWS:   cfg.rows = val[DIM_W-1:0];
      REG_MARGIN: cfg.margin = val[MRG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int cols, int rows, int mrg);
    reg_write(REG_COLS, cols);
    reg_write(REG_ROWS, rows);
    reg_write(REG_MARGIN, mrg);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || in_if.valid || result_due.size() != 0);
  endtask

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  // command beat driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) result_due.push_back(crop_step(1, drv_item));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          drv_item = cmd_backlog.pop_front();
          in_if.valid <= 1'b1;
          in_if.cmd <= drv_item.cmd;
          in_if.row <= drv_item.row;
          in_if.col <= drv_item.col;
          in_if.pixel_in <= drv_item.pix;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result beat monitor and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (result_due.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          mon_exp = result_due.pop_front();
          cmp_field("pixel_out", 32'(mon_exp.pixel), 32'(out_if.pixel_out));
          cmp_field("crop_left", 32'(mon_exp.left), 32'(out_if.crop_left));
          cmp_field("crop_top", 32'(mon_exp.top), 32'(out_if.crop_top));
          cmp_field("crop_width", 32'(mon_exp.width), 32'(out_if.crop_width));
          cmp_field("crop_height", 32'(mon_exp.height), 32'(out_if.crop_height));
          cmp_field("empty_res", 32'(mon_exp.empty), 32'(out_if.empty_res));
          cmp_field("out_of_range", 32'(mon_exp.oor), 32'(out_if.out_of_range));
        end
      end
      if (rx_left == 0) begin
        if (!long_hold_done && cmd_backlog.size() > 40) begin
          rx_mode = RX_HOLD;
          rx_left = 64;
          long_hold_done = 1'b1;
        end else begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = (rx_mode == RX_HOLD) ? $urandom_range(2, 12) : $urandom_range(4, 40);
        end
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= 1'b0;
      endcase
    end
  end

  initial begin
    #800000;
    $display("tb_foreground_bbox_crop: FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = '0;
    in_if.row = '0;
    in_if.col = '0;
    in_if.pixel_in = '0;
    out_if.ready = 1'b0;
    cfg.cols = COLS_RST;
    cfg.rows = ROWS_RST;
    cfg.margin = MARGIN_RST;
    clear_box(0);
    clear_box(1);
    planned = 0;
    fail_cnt = 0;
    burst_left = 0;
    gap_left = 0;
    rx_mode = RX_FREE;
    rx_left = 0;
    long_hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: empty frame, unused command, corners, margin clamps
    plan_item(mk(CMD_READ, 0, 0, 0));
    plan_item(mk(CMD_UNUSED, 511, 511, 16'hFFFF));
    plan_item(mk(CMD_NEW_FRAME, 0, 0, 0));
    plan_item(mk(CMD_WRITE, 0, 0, 0));
    plan_item(mk(CMD_READ, 0, 0, 0));
    plan_item(mk(CMD_WRITE, 511, 511, 16'hFFFF));
    plan_item(mk(CMD_READ, 0, 0, 0));
    plan_item(mk(CMD_READ, 10, 10, 0));
    plan_item(mk(CMD_READ, 11, 0, 0));
    plan_item(mk(CMD_WRITE, 0, 0, 1));
    plan_item(mk(CMD_READ, 511, 511, 0));
    plan_item(mk(CMD_WRITE, 200, 300, 16'h8000));
    plan_item(mk(CMD_UNUSED, 0, 0, 0));
    plan_item(mk(CMD_NEW_FRAME, 511, 511, 16'hFFFF));
    plan_item(mk(CMD_READ, 0, 0, 0));
    wait_idle();

    // small image, no margin: writes past the edges, single-pixel box with a zero-size crop
    set_geometry(20, 12, 0);
    plan_item(mk(CMD_WRITE, 12, 5, 1));
    plan_item(mk(CMD_WRITE, 3, 20, 1));
    plan_item(mk(CMD_WRITE, 11, 19, 16'hAAAA));
    plan_item(mk(CMD_READ, 0, 0, 0));
    plan_item(mk(CMD_READ, 0, 1, 0));
    plan_item(mk(CMD_WRITE, 2, 4, 16'h5555));
    plan_item(mk(CMD_READ, 9, 15, 0));
    plan_item(mk(CMD_NEW_FRAME, 0, 0, 0));
    plan_item(mk(CMD_UNUSED, 0, 0, 0));
    wait_idle();

    set_geometry(1023, 1023, 255);
    plan_traffic(90);
    wait_idle();
    set_geometry(16, 16, 0);
    plan_traffic(90);
    wait_idle();
    set_geometry(0, 0, 7);
    plan_traffic(50);
    wait_idle();
    set_geometry(1, 1, 1);
    plan_traffic(70);
    wait_idle();
    set_geometry(512, 512, 0);
    plan_traffic(90);
    wait_idle();
    repeat (3) begin
      set_geometry(($urandom_range(0, 3) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 40),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 40),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
      plan_traffic(90);
      wait_idle();
    end
    set_geometry(COLS_RST, ROWS_RST, MARGIN_RST);
    plan_traffic(90);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (result_due.size() != 0) begin
      $error("%0d result beats never arrived", result_due.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb_foreground_bbox_crop: PASS");
    end else begin
      $display("tb_foreground_bbox_crop: FAIL");
    end
    $finish;
  end

endmodule
